FILE: rtl/gpio_pkg.sv
package gpio_pkg;

  localparam int PIN_COUNT = 16;
  localparam logic [15:0] PIN_MASK = 16'((33'd1 << PIN_COUNT) - 33'd1);
  localparam logic [31:0] CFG_RESET = 32'h4444_4444;
  localparam logic [3:0] CFG_NIBBLE_RESET = 4'h4;
  localparam int KEY_BIT = 16;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_CFG_LOW   = 3'd0,
    REG_CFG_HIGH  = 3'd1,
    REG_INPUT     = 3'd2,
    REG_OUTPUT    = 3'd3,
    REG_SET_RESET = 3'd4,
    REG_RESET     = 3'd5,
    REG_LOCK      = 3'd6
  } reg_sel_t;

  typedef enum logic [1:0] {
    KEY_IDLE  = 2'd0,
    KEY_ONE   = 2'd1,
    KEY_ZERO  = 2'd2,
    KEY_ARMED = 2'd3
  } key_stage_t;

  typedef struct packed {
    op_t         op;
    reg_sel_t    reg_sel;
    logic [31:0] wr_data;
    logic [15:0] pin_levels;
  } req_t;

  typedef struct packed {
    logic [31:0] rd_data;
    logic [15:0] pins_out;
  } rsp_t;

endpackage

FILE: rtl/gpio_port_with_config_lock.sv
// 16-pin GPIO port register block. Each request is one read or write of a
// register (config low/high, input data, output data, set/reset, reset, lock)
// and yields exactly one response carrying the read data (zero for writes)
// and the output data driving the pads after the access. A request is taken
// every cycle: register update and response are formed combinationally
// and held in a single response register, valid in the next cycle. The port
// stalls only while that register holds a response not yet taken. The
// lock sequence is write key 1, write key 0, write key 1 with the same lock
// bits, then a read of the lock register; that read still shows key 0 and
// activates the lock until reset, freezing the config nibbles of locked pins
// and the lock register.
module gpio_port_with_config_lock (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  gpio_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output gpio_pkg::rsp_t rsp
);

  logic [31:0]          cfg_low;
  logic [31:0]          cfg_high;
  logic [15:0]          out_data;
  logic [15:0]          lock_bits;
  logic                 lock_active;
  gpio_pkg::key_stage_t key_stage;

  logic [31:0]          cfg_low_next;
  logic [31:0]          cfg_high_next;
  logic [15:0]          out_data_next;
  logic [15:0]          lock_bits_next;
  logic                 lock_active_next;
  gpio_pkg::key_stage_t key_stage_next;
  logic [31:0]          rd_data;

  logic                 accept;
  logic                 is_write;
  logic                 is_read;
  logic [15:0]          lock_wr_bits;
  logic                 lock_key;
  logic                 lock_same;
  logic [31:0]          cfg_low_merged;
  logic [31:0]          cfg_high_merged;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign is_write  = req.op == gpio_pkg::OP_WRITE;
  assign is_read   = req.op == gpio_pkg::OP_READ;

  assign lock_wr_bits = req.wr_data[15:0] & gpio_pkg::PIN_MASK;
  assign lock_key     = req.wr_data[gpio_pkg::KEY_BIT];
  assign lock_same    = lock_wr_bits == lock_bits;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      if (i >= gpio_pkg::PIN_COUNT) begin
        cfg_low_merged[4*i +: 4] = gpio_pkg::CFG_NIBBLE_RESET;
      end else if (lock_active && lock_bits[i]) begin
        cfg_low_merged[4*i +: 4] = cfg_low[4*i +: 4];
      end else begin
        cfg_low_merged[4*i +: 4] = req.wr_data[4*i +: 4];
      end
      if (i + 8 >= gpio_pkg::PIN_COUNT) begin
        cfg_high_merged[4*i +: 4] = gpio_pkg::CFG_NIBBLE_RESET;
      end else if (lock_active && lock_bits[i+8]) begin
        cfg_high_merged[4*i +: 4] = cfg_high[4*i +: 4];
      end else begin
        cfg_high_merged[4*i +: 4] = req.wr_data[4*i +: 4];
      end
    end
  end

  // register updates and key sequence
  always_comb begin
    cfg_low_next     = cfg_low;
    cfg_high_next    = cfg_high;
    out_data_next    = out_data;
    lock_bits_next   = lock_bits;
    lock_active_next = lock_active;
    key_stage_next   = key_stage;
    if (is_write) begin
      unique case (req.reg_sel)
        gpio_pkg::REG_CFG_LOW:  cfg_low_next  = cfg_low_merged;
        gpio_pkg::REG_CFG_HIGH: cfg_high_next = cfg_high_merged;
        gpio_pkg::REG_OUTPUT:   out_data_next = req.wr_data[15:0] & gpio_pkg::PIN_MASK;
        gpio_pkg::REG_SET_RESET: begin
          out_data_next = ((out_data & ~req.wr_data[31:16]) | req.wr_data[15:0])
                          & gpio_pkg::PIN_MASK;
        end
        gpio_pkg::REG_RESET: begin
          out_data_next = out_data & ~req.wr_data[15:0] & gpio_pkg::PIN_MASK;
        end
        gpio_pkg::REG_LOCK: begin
          if (!lock_active) begin
            lock_bits_next = lock_wr_bits;
            if (key_stage == gpio_pkg::KEY_ONE && !lock_key && lock_same) begin
              key_stage_next = gpio_pkg::KEY_ZERO;
            end else if (key_stage == gpio_pkg::KEY_ZERO && lock_key && lock_same) begin
              key_stage_next = gpio_pkg::KEY_ARMED;
            end else if (lock_key) begin
              key_stage_next = gpio_pkg::KEY_ONE;
            end else begin
              key_stage_next = gpio_pkg::KEY_IDLE;
            end
          end
        end
        default: begin
        end
      endcase
    end else if (req.reg_sel == gpio_pkg::REG_LOCK && !lock_active) begin
      if (key_stage == gpio_pkg::KEY_ARMED) begin
        lock_active_next = 1'b1;
      end
      key_stage_next = gpio_pkg::KEY_IDLE;
    end
  end

  // read data
  always_comb begin
    rd_data = '0;
    if (is_read) begin
      unique case (req.reg_sel)
        gpio_pkg::REG_CFG_LOW:  rd_data = cfg_low;
        gpio_pkg::REG_CFG_HIGH: rd_data = cfg_high;
        gpio_pkg::REG_INPUT:    rd_data = {16'd0, req.pin_levels & gpio_pkg::PIN_MASK};
        gpio_pkg::REG_OUTPUT:   rd_data = {16'd0, out_data};
        gpio_pkg::REG_LOCK:     rd_data = {15'd0, lock_active, lock_bits};
        default:                rd_data = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_low     <= gpio_pkg::CFG_RESET;
      cfg_high    <= gpio_pkg::CFG_RESET;
      out_data    <= '0;
      lock_bits   <= '0;
      lock_active <= 1'b0;
      key_stage   <= gpio_pkg::KEY_IDLE;
    end else if (accept) begin
      cfg_low     <= cfg_low_next;
      cfg_high    <= cfg_high_next;
      out_data    <= out_data_next;
      lock_bits   <= lock_bits_next;
      lock_active <= lock_active_next;
      key_stage   <= key_stage_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.rd_data  <= rd_data;
      rsp.pins_out <= out_data_next;
    end
  end

  a_accept_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("accepted transfer produced no response");

  a_lock_sticky: assert property (@(posedge clk) disable iff (rst)
    lock_active |=> lock_active && $stable(lock_bits))
    else $error("active lock changed before reset");

  a_pins_match: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.pins_out == out_data)
    else $error("response pins differ from output data register");

  a_lock_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(lock_active) |-> $past(accept && is_read && req.reg_sel == gpio_pkg::REG_LOCK))
    else $error("lock activated without a lock read");

endmodule
